// ===== hw/rtl/mpsm_pkg.sv =====
`default_nettype none
package mpsm_pkg;

    // defaults for the top-level parameters
    localparam int MAX_NODES_DEF    = 1024;
    localparam int MAX_PATTERNS_DEF = 256;
    localparam int MAX_DEPTH_DEF    = 32;

    // reports for one text byte are capped here
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // input action codes (s_tuser)
    localparam logic [1:0] ACT_PCHAR = 2'd0;
    localparam logic [1:0] ACT_PEND  = 2'd1;
    localparam logic [1:0] ACT_TEXT  = 2'd2;
    localparam logic [1:0] ACT_NEW   = 2'd3;

    // result kinds (m_tuser)
    localparam logic KIND_MATCH  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // insert status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_LONG  = 2'd3;

    // datapath operations issued by the controller
    localparam int OP_W = 6;
    localparam logic [OP_W-1:0] OP_NONE     = 6'd0;
    localparam logic [OP_W-1:0] OP_P_ERR3   = 6'd1;
    localparam logic [OP_W-1:0] OP_P_FINIT  = 6'd2;
    localparam logic [OP_W-1:0] OP_FIND     = 6'd3;
    localparam logic [OP_W-1:0] OP_P_TAKE   = 6'd4;
    localparam logic [OP_W-1:0] OP_P_ERR2   = 6'd5;
    localparam logic [OP_W-1:0] OP_P_NEW    = 6'd6;
    localparam logic [OP_W-1:0] OP_E_EMIT   = 6'd7;
    localparam logic [OP_W-1:0] OP_RB_INIT  = 6'd8;
    localparam logic [OP_W-1:0] OP_RB_POP   = 6'd9;
    localparam logic [OP_W-1:0] OP_RB_LATCH = 6'd10;
    localparam logic [OP_W-1:0] OP_RB_KIDS  = 6'd11;
    localparam logic [OP_W-1:0] OP_RB_RDPS  = 6'd12;
    localparam logic [OP_W-1:0] OP_RB_PS    = 6'd13;
    localparam logic [OP_W-1:0] OP_RB_FSET  = 6'd14;
    localparam logic [OP_W-1:0] OP_RB_FNEXT = 6'd15;
    localparam logic [OP_W-1:0] OP_RB_FAILC = 6'd16;
    localparam logic [OP_W-1:0] OP_RB_FAIL0 = 6'd17;
    localparam logic [OP_W-1:0] OP_RB_ORD   = 6'd18;
    localparam logic [OP_W-1:0] OP_RB_OCHK  = 6'd19;
    localparam logic [OP_W-1:0] OP_RB_OLW   = 6'd20;
    localparam logic [OP_W-1:0] OP_RB_DONE  = 6'd21;
    localparam logic [OP_W-1:0] OP_M_INIT   = 6'd22;
    localparam logic [OP_W-1:0] OP_M_TAKE   = 6'd23;
    localparam logic [OP_W-1:0] OP_M_FRD    = 6'd24;
    localparam logic [OP_W-1:0] OP_M_FAIL   = 6'd25;
    localparam logic [OP_W-1:0] OP_M_SET    = 6'd26;
    localparam logic [OP_W-1:0] OP_M_NEMIT  = 6'd27;
    localparam logic [OP_W-1:0] OP_M_NSKIP  = 6'd28;
    localparam logic [OP_W-1:0] OP_M_CRD    = 6'd29;
    localparam logic [OP_W-1:0] OP_M_CEMIT  = 6'd30;

    typedef struct packed {
        logic            accept;
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic err_nz;
        logic len_full;
        logic nodes_full;
        logic stale;
        logic found;
        logic find_hit;
        logic find_miss;
        logic kids_done;
        logic q_empty;
        logic n_root;
        logic p_root;
        logic f_root;
        logic mn_root;
        logic o_root;
        logic n_term;
        logic info_term;
        logic cnt_full;
        logic out_free;
    } st_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mpsm_ram.sv =====
`default_nettype none
module mpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/mpsm_ctrl.sv =====
`default_nettype none
module mpsm_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    input  wire logic [1:0]      s_action,
    output logic                 s_tready,
    input  wire mpsm_pkg::st_t   st,
    output mpsm_pkg::cmd_t       cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_P0       = 5'd1;
    localparam logic [4:0] S_P1       = 5'd2;
    localparam logic [4:0] S_FIND     = 5'd3;
    localparam logic [4:0] S_E0       = 5'd4;
    localparam logic [4:0] S_X0       = 5'd5;
    localparam logic [4:0] S_RB_POP   = 5'd6;
    localparam logic [4:0] S_RB_LAT   = 5'd7;
    localparam logic [4:0] S_RB_KIDS  = 5'd8;
    localparam logic [4:0] S_RB_RDPS  = 5'd9;
    localparam logic [4:0] S_RB_PS    = 5'd10;
    localparam logic [4:0] S_RB_PCHK  = 5'd11;
    localparam logic [4:0] S_RB_FRET  = 5'd12;
    localparam logic [4:0] S_RB_FLOAD = 5'd13;
    localparam logic [4:0] S_RB_OTEST = 5'd14;
    localparam logic [4:0] S_RB_OCHK  = 5'd15;
    localparam logic [4:0] S_RB_OLW   = 5'd16;
    localparam logic [4:0] S_RB_DONE  = 5'd17;
    localparam logic [4:0] S_M_RET1   = 5'd18;
    localparam logic [4:0] S_M_FAIL   = 5'd19;
    localparam logic [4:0] S_M_RET2   = 5'd20;
    localparam logic [4:0] S_M_SET    = 5'd21;
    localparam logic [4:0] S_M_N      = 5'd22;
    localparam logic [4:0] S_M_CTEST  = 5'd23;
    localparam logic [4:0] S_M_CE     = 5'd24;

    logic [4:0] state_reg, state_next;
    logic [4:0] ret_reg, ret_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd.accept = 1'b0;
        cmd.op     = mpsm_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    case (s_action)
                        mpsm_pkg::ACT_PCHAR: state_next = S_P0;
                        mpsm_pkg::ACT_PEND:  state_next = S_E0;
                        mpsm_pkg::ACT_TEXT:  state_next = S_X0;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_P0:
            begin
                state_next = S_IDLE;
                if (st.err_nz)
                begin
                    cmd.op = mpsm_pkg::OP_NONE;
                end
                else if (st.len_full)
                begin
                    cmd.op = mpsm_pkg::OP_P_ERR3;
                end
                else
                begin
                    cmd.op     = mpsm_pkg::OP_P_FINIT;
                    ret_next   = S_P1;
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                cmd.op = mpsm_pkg::OP_FIND;
                if (st.find_hit || st.find_miss)
                begin
                    state_next = ret_reg;
                end
            end
            S_P1:
            begin
                state_next = S_IDLE;
                if (st.found)
                begin
                    cmd.op = mpsm_pkg::OP_P_TAKE;
                end
                else if (st.nodes_full)
                begin
                    cmd.op = mpsm_pkg::OP_P_ERR2;
                end
                else
                begin
                    cmd.op = mpsm_pkg::OP_P_NEW;
                end
            end
            S_E0:
            begin
                if (st.out_free)
                begin
                    cmd.op     = mpsm_pkg::OP_E_EMIT;
                    state_next = S_IDLE;
                end
            end
            S_X0:
            begin
                if (st.stale)
                begin
                    cmd.op     = mpsm_pkg::OP_RB_INIT;
                    state_next = S_RB_POP;
                end
                else
                begin
                    cmd.op     = mpsm_pkg::OP_M_INIT;
                    ret_next   = S_M_RET1;
                    state_next = S_FIND;
                end
            end
            S_RB_POP:
            begin
                if (st.q_empty)
                begin
                    state_next = S_RB_DONE;
                end
                else
                begin
                    cmd.op     = mpsm_pkg::OP_RB_POP;
                    state_next = S_RB_LAT;
                end
            end
            S_RB_LAT:
            begin
                cmd.op     = mpsm_pkg::OP_RB_LATCH;
                state_next = S_RB_KIDS;
            end
            S_RB_KIDS:
            begin
                cmd.op = mpsm_pkg::OP_RB_KIDS;
                if (st.kids_done)
                begin
                    state_next = st.n_root ? S_RB_POP : S_RB_RDPS;
                end
            end
            S_RB_RDPS:
            begin
                cmd.op     = mpsm_pkg::OP_RB_RDPS;
                state_next = S_RB_PS;
            end
            S_RB_PS:
            begin
                cmd.op     = mpsm_pkg::OP_RB_PS;
                state_next = S_RB_PCHK;
            end
            S_RB_PCHK:
            begin
                if (st.p_root)
                begin
                    cmd.op     = mpsm_pkg::OP_RB_FAIL0;
                    state_next = S_RB_OTEST;
                end
                else
                begin
                    cmd.op     = mpsm_pkg::OP_RB_FSET;
                    ret_next   = S_RB_FRET;
                    state_next = S_FIND;
                end
            end
            S_RB_FRET:
            begin
                if (st.found)
                begin
                    cmd.op     = mpsm_pkg::OP_RB_FAILC;
                    state_next = S_RB_OTEST;
                end
                else if (st.f_root)
                begin
                    cmd.op     = mpsm_pkg::OP_RB_FAIL0;
                    state_next = S_RB_OTEST;
                end
                else
                begin
                    cmd.op     = mpsm_pkg::OP_RB_FNEXT;
                    state_next = S_RB_FLOAD;
                end
            end
            S_RB_FLOAD:
            begin
                cmd.op     = mpsm_pkg::OP_RB_FSET;
                ret_next   = S_RB_FRET;
                state_next = S_FIND;
            end
            S_RB_OTEST:
            begin
                if (st.o_root)
                begin
                    state_next = S_RB_OLW;
                end
                else
                begin
                    cmd.op     = mpsm_pkg::OP_RB_ORD;
                    state_next = S_RB_OCHK;
                end
            end
            S_RB_OCHK:
            begin
                cmd.op     = mpsm_pkg::OP_RB_OCHK;
                state_next = st.info_term ? S_RB_OLW : S_RB_OTEST;
            end
            S_RB_OLW:
            begin
                cmd.op     = mpsm_pkg::OP_RB_OLW;
                state_next = S_RB_POP;
            end
            S_RB_DONE:
            begin
                cmd.op     = mpsm_pkg::OP_RB_DONE;
                state_next = S_X0;
            end
            S_M_RET1:
            begin
                if (st.found)
                begin
                    cmd.op     = mpsm_pkg::OP_M_TAKE;
                    state_next = S_M_SET;
                end
                else
                begin
                    cmd.op     = mpsm_pkg::OP_M_FRD;
                    state_next = S_M_FAIL;
                end
            end
            S_M_FAIL:
            begin
                cmd.op     = mpsm_pkg::OP_M_FAIL;
                ret_next   = S_M_RET2;
                state_next = S_FIND;
            end
            S_M_RET2:
            begin
                if (st.found)
                begin
                    cmd.op     = mpsm_pkg::OP_M_TAKE;
                    state_next = S_M_SET;
                end
                else if (st.mn_root)
                begin
                    state_next = S_M_SET;
                end
                else
                begin
                    cmd.op     = mpsm_pkg::OP_M_FRD;
                    state_next = S_M_FAIL;
                end
            end
            S_M_SET:
            begin
                cmd.op     = mpsm_pkg::OP_M_SET;
                state_next = S_M_N;
            end
            S_M_N:
            begin
                if (!st.n_term)
                begin
                    cmd.op     = mpsm_pkg::OP_M_NSKIP;
                    state_next = S_M_CTEST;
                end
                else if (st.out_free)
                begin
                    cmd.op     = mpsm_pkg::OP_M_NEMIT;
                    state_next = S_M_CTEST;
                end
            end
            S_M_CTEST:
            begin
                if (st.o_root || st.cnt_full)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = mpsm_pkg::OP_M_CRD;
                    state_next = S_M_CE;
                end
            end
            S_M_CE:
            begin
                if (st.out_free)
                begin
                    cmd.op     = mpsm_pkg::OP_M_CEMIT;
                    state_next = S_M_CTEST;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/mpsm_dpath.sv =====
`default_nettype none
module mpsm_dpath #(
    parameter int MAX_NODES    = mpsm_pkg::MAX_NODES_DEF,
    parameter int MAX_PATTERNS = mpsm_pkg::MAX_PATTERNS_DEF,
    parameter int MAX_DEPTH    = mpsm_pkg::MAX_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mpsm_pkg::cmd_t   cmd,
    output mpsm_pkg::st_t         st,
    input  wire logic [1:0]       in_action,
    input  wire logic [7:0]       in_symbol,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [47:0]           m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int PW  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int PCW = $clog2(MAX_PATTERNS + 1);
    localparam int DW  = $clog2(MAX_DEPTH + 1);
    localparam int CW  = mpsm_pkg::CNT_W;
    localparam logic [NW-1:0] ROOT = '0;

    // trie state
    logic [7:0]     sym_reg, sym_next;
    logic [NCW-1:0] nu_reg, nu_next;
    logic [PCW-1:0] pu_reg, pu_next;
    logic [NW-1:0]  cur_reg, cur_next;
    logic [DW-1:0]  len_reg, len_next;
    logic [1:0]     err_reg, err_next;
    logic           stale_reg, stale_next;
    logic [NW-1:0]  scan_reg, scan_next;
    logic [31:0]    tpos_reg, tpos_next;
    // child search
    logic [NW-1:0]  fp_reg, fp_next;
    logic [7:0]     fs_reg, fs_next;
    logic [NCW-1:0] j_reg, j_next;
    logic           vld_reg, vld_next;
    logic [NW-1:0]  jd_reg, jd_next;
    logic           found_reg, found_next;
    logic [NW-1:0]  child_reg, child_next;
    // link rebuild walk
    logic [NCW-1:0] head_reg, head_next;
    logic [NCW-1:0] tail_reg, tail_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [NW-1:0]  p_reg, p_next;
    logic [7:0]     s_reg, s_next;
    logic [NW-1:0]  f_reg, f_next;
    logic [NW-1:0]  o_reg, o_next;
    // text scan
    logic [NW-1:0]  mn_reg, mn_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    // output word
    logic           ov_reg, ov_next;
    logic           ok_reg, ok_next;
    logic [7:0]     opid_reg, opid_next;
    logic [31:0]    ostart_reg, ostart_next;
    logic [1:0]     ost_reg, ost_next;
    logic           olast_reg, olast_next;

    // memory ports
    logic             ps_we, psa_re, psb_re, q_we, q_re, info_re;
    logic             fail_we, olink_we, tp_we, dep_we;
    logic [NW-1:0]    ps_wa, q_wa, fail_wa, olink_wa, tp_wa, info_ra;
    logic [NW+7:0]    ps_wd, psa_rd, psb_rd;
    logic [NW-1:0]    q_wd, q_rd, fail_wd, fail_rd, olink_wd, olink_rd;
    logic [PW:0]      tp_wd, tp_rd;
    logic [DW-1:0]    dep_wd, dep_rd;

    logic             find_hit, kid_hit, out_free;
    logic [1:0]       e_status;

    assign find_hit = vld_reg && (psa_rd[NW+7:8] == fp_reg) && (psa_rd[7:0] == fs_reg);
    assign kid_hit  = vld_reg && (psa_rd[NW+7:8] == n_reg) &&
                      (tail_reg < NCW'(MAX_NODES));
    assign out_free = !ov_reg || m_tready;

    always_comb
    begin
        if (err_reg != mpsm_pkg::ST_OK)
        begin
            e_status = err_reg;
        end
        else if (len_reg == '0)
        begin
            e_status = mpsm_pkg::ST_EMPTY;
        end
        else if (pu_reg >= PCW'(MAX_PATTERNS))
        begin
            e_status = mpsm_pkg::ST_FULL;
        end
        else
        begin
            e_status = mpsm_pkg::ST_OK;
        end
    end

    always_comb
    begin
        st.err_nz     = (err_reg != mpsm_pkg::ST_OK);
        st.len_full   = (len_reg >= DW'(MAX_DEPTH));
        st.nodes_full = (nu_reg >= NCW'(MAX_NODES));
        st.stale      = stale_reg;
        st.found      = found_reg;
        st.find_hit   = find_hit;
        st.find_miss  = !find_hit && !vld_reg && (j_reg >= nu_reg);
        st.kids_done  = !vld_reg && (j_reg >= nu_reg);
        st.q_empty    = (head_reg == tail_reg);
        st.n_root     = (n_reg == ROOT);
        st.p_root     = (p_reg == ROOT);
        st.f_root     = (f_reg == ROOT);
        st.mn_root    = (mn_reg == ROOT);
        st.o_root     = (o_reg == ROOT);
        // the root never holds a pattern
        st.n_term     = (mn_reg != ROOT) && tp_rd[PW];
        st.info_term  = tp_rd[PW];
        st.cnt_full   = (cnt_reg >= CW'(mpsm_pkg::MAX_RESULTS));
        st.out_free   = out_free;
    end

    always_comb
    begin
        sym_next    = sym_reg;
        nu_next     = nu_reg;
        pu_next     = pu_reg;
        cur_next    = cur_reg;
        len_next    = len_reg;
        err_next    = err_reg;
        stale_next  = stale_reg;
        scan_next   = scan_reg;
        tpos_next   = tpos_reg;
        fp_next     = fp_reg;
        fs_next     = fs_reg;
        j_next      = j_reg;
        vld_next    = vld_reg;
        jd_next     = jd_reg;
        found_next  = found_reg;
        child_next  = child_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        n_next      = n_reg;
        p_next      = p_reg;
        s_next      = s_reg;
        f_next      = f_reg;
        o_next      = o_reg;
        mn_next     = mn_reg;
        cnt_next    = cnt_reg;
        ov_next     = ov_reg && !m_tready;
        ok_next     = ok_reg;
        opid_next   = opid_reg;
        ostart_next = ostart_reg;
        ost_next    = ost_reg;
        olast_next  = olast_reg;

        ps_we    = 1'b0;
        ps_wa    = nu_reg[NW-1:0];
        ps_wd    = {cur_reg, sym_reg};
        psa_re   = 1'b0;
        psb_re   = 1'b0;
        q_we     = 1'b0;
        q_wa     = tail_reg[NW-1:0];
        q_wd     = jd_reg;
        q_re     = 1'b0;
        fail_we  = 1'b0;
        fail_wa  = n_reg;
        fail_wd  = ROOT;
        olink_we = 1'b0;
        olink_wa = n_reg;
        olink_wd = o_reg;
        tp_we    = 1'b0;
        tp_wa    = nu_reg[NW-1:0];
        tp_wd    = '0;
        dep_we   = 1'b0;
        dep_wd   = len_reg + DW'(1);
        info_re  = 1'b0;
        info_ra  = mn_reg;

        if (cmd.accept)
        begin
            sym_next = in_symbol;
            if (in_action == mpsm_pkg::ACT_PCHAR || in_action == mpsm_pkg::ACT_PEND)
            begin
                stale_next = 1'b1;
            end
            if (in_action == mpsm_pkg::ACT_NEW)
            begin
                scan_next = ROOT;
                tpos_next = '0;
            end
        end

        case (cmd.op)
            mpsm_pkg::OP_P_ERR3:
            begin
                err_next = mpsm_pkg::ST_LONG;
            end
            mpsm_pkg::OP_P_FINIT:
            begin
                fp_next    = cur_reg;
                fs_next    = sym_reg;
                j_next     = NCW'(1);
                vld_next   = 1'b0;
                found_next = 1'b0;
            end
            mpsm_pkg::OP_FIND:
            begin
                if (find_hit)
                begin
                    found_next = 1'b1;
                    child_next = jd_reg;
                    vld_next   = 1'b0;
                end
                else if (j_reg < nu_reg)
                begin
                    psa_re   = 1'b1;
                    jd_next  = j_reg[NW-1:0];
                    j_next   = j_reg + NCW'(1);
                    vld_next = 1'b1;
                end
                else
                begin
                    vld_next = 1'b0;
                end
            end
            mpsm_pkg::OP_P_TAKE:
            begin
                cur_next = child_reg;
                len_next = len_reg + DW'(1);
            end
            mpsm_pkg::OP_P_ERR2:
            begin
                err_next = mpsm_pkg::ST_FULL;
            end
            mpsm_pkg::OP_P_NEW:
            begin
                ps_we    = 1'b1;
                fail_we  = 1'b1;
                fail_wa  = nu_reg[NW-1:0];
                olink_we = 1'b1;
                olink_wa = nu_reg[NW-1:0];
                olink_wd = ROOT;
                tp_we    = 1'b1;
                dep_we   = 1'b1;
                nu_next  = nu_reg + NCW'(1);
                cur_next = nu_reg[NW-1:0];
                len_next = len_reg + DW'(1);
            end
            mpsm_pkg::OP_E_EMIT:
            begin
                ov_next     = 1'b1;
                ok_next     = mpsm_pkg::KIND_STATUS;
                opid_next   = '0;
                ostart_next = '0;
                ost_next    = e_status;
                olast_next  = 1'b1;
                if (e_status == mpsm_pkg::ST_OK)
                begin
                    opid_next = 8'(pu_reg);
                    tp_we     = 1'b1;
                    tp_wa     = cur_reg;
                    tp_wd     = {1'b1, PW'(pu_reg)};
                    pu_next   = pu_reg + PCW'(1);
                end
                cur_next = ROOT;
                len_next = '0;
                err_next = mpsm_pkg::ST_OK;
            end
            mpsm_pkg::OP_RB_INIT:
            begin
                fail_we   = 1'b1;
                fail_wa   = ROOT;
                olink_we  = 1'b1;
                olink_wa  = ROOT;
                olink_wd  = ROOT;
                q_we      = 1'b1;
                q_wa      = ROOT;
                q_wd      = ROOT;
                head_next = '0;
                tail_next = NCW'(1);
            end
            mpsm_pkg::OP_RB_POP:
            begin
                q_re      = 1'b1;
                head_next = head_reg + NCW'(1);
            end
            mpsm_pkg::OP_RB_LATCH:
            begin
                n_next   = q_rd;
                j_next   = NCW'(1);
                vld_next = 1'b0;
            end
            mpsm_pkg::OP_RB_KIDS:
            begin
                if (kid_hit)
                begin
                    q_we      = 1'b1;
                    tail_next = tail_reg + NCW'(1);
                end
                if (j_reg < nu_reg)
                begin
                    psa_re   = 1'b1;
                    jd_next  = j_reg[NW-1:0];
                    j_next   = j_reg + NCW'(1);
                    vld_next = 1'b1;
                end
                else
                begin
                    vld_next = 1'b0;
                end
            end
            mpsm_pkg::OP_RB_RDPS:
            begin
                psb_re = 1'b1;
            end
            mpsm_pkg::OP_RB_PS:
            begin
                p_next  = psb_rd[NW+7:8];
                s_next  = psb_rd[7:0];
                info_re = 1'b1;
                info_ra = psb_rd[NW+7:8];
            end
            mpsm_pkg::OP_RB_FSET:
            begin
                f_next     = fail_rd;
                fp_next    = fail_rd;
                fs_next    = s_reg;
                j_next     = NCW'(1);
                vld_next   = 1'b0;
                found_next = 1'b0;
            end
            mpsm_pkg::OP_RB_FNEXT:
            begin
                info_re = 1'b1;
                info_ra = f_reg;
            end
            mpsm_pkg::OP_RB_FAILC:
            begin
                fail_we = 1'b1;
                fail_wd = child_reg;
                o_next  = child_reg;
            end
            mpsm_pkg::OP_RB_FAIL0:
            begin
                fail_we = 1'b1;
                o_next  = ROOT;
            end
            mpsm_pkg::OP_RB_ORD:
            begin
                info_re = 1'b1;
                info_ra = o_reg;
            end
            mpsm_pkg::OP_RB_OCHK:
            begin
                if (!tp_rd[PW])
                begin
                    o_next = fail_rd;
                end
            end
            mpsm_pkg::OP_RB_OLW:
            begin
                olink_we = 1'b1;
            end
            mpsm_pkg::OP_RB_DONE:
            begin
                stale_next = 1'b0;
                scan_next  = ROOT;
                tpos_next  = '0;
            end
            mpsm_pkg::OP_M_INIT:
            begin
                mn_next    = scan_reg;
                fp_next    = scan_reg;
                fs_next    = sym_reg;
                j_next     = NCW'(1);
                vld_next   = 1'b0;
                found_next = 1'b0;
            end
            mpsm_pkg::OP_M_TAKE:
            begin
                mn_next = child_reg;
            end
            mpsm_pkg::OP_M_FRD:
            begin
                info_re = 1'b1;
                info_ra = mn_reg;
            end
            mpsm_pkg::OP_M_FAIL:
            begin
                mn_next    = fail_rd;
                fp_next    = fail_rd;
                fs_next    = sym_reg;
                j_next     = NCW'(1);
                vld_next   = 1'b0;
                found_next = 1'b0;
            end
            mpsm_pkg::OP_M_SET:
            begin
                scan_next = mn_reg;
                tpos_next = tpos_reg + 32'd1;
                cnt_next  = '0;
                info_re   = 1'b1;
                info_ra   = mn_reg;
            end
            mpsm_pkg::OP_M_NEMIT:
            begin
                ov_next     = 1'b1;
                ok_next     = mpsm_pkg::KIND_MATCH;
                opid_next   = 8'(tp_rd[PW-1:0]);
                ostart_next = tpos_reg - 32'(dep_rd);
                ost_next    = mpsm_pkg::ST_OK;
                olast_next  = (olink_rd == ROOT);
                cnt_next    = CW'(1);
                o_next      = olink_rd;
            end
            mpsm_pkg::OP_M_NSKIP:
            begin
                o_next = olink_rd;
            end
            mpsm_pkg::OP_M_CRD:
            begin
                info_re = 1'b1;
                info_ra = o_reg;
            end
            mpsm_pkg::OP_M_CEMIT:
            begin
                ov_next     = 1'b1;
                ok_next     = mpsm_pkg::KIND_MATCH;
                opid_next   = 8'(tp_rd[PW-1:0]);
                ostart_next = tpos_reg - 32'(dep_rd);
                ost_next    = mpsm_pkg::ST_OK;
                olast_next  = (olink_rd == ROOT) ||
                              (cnt_reg == CW'(mpsm_pkg::MAX_RESULTS - 1));
                cnt_next    = cnt_reg + CW'(1);
                o_next      = olink_rd;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nu_reg    <= NCW'(1);
            pu_reg    <= '0;
            cur_reg   <= ROOT;
            len_reg   <= '0;
            err_reg   <= mpsm_pkg::ST_OK;
            stale_reg <= 1'b1;
            scan_reg  <= ROOT;
            tpos_reg  <= '0;
            j_reg     <= '0;
            vld_reg   <= 1'b0;
            found_reg <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            nu_reg    <= nu_next;
            pu_reg    <= pu_next;
            cur_reg   <= cur_next;
            len_reg   <= len_next;
            err_reg   <= err_next;
            stale_reg <= stale_next;
            scan_reg  <= scan_next;
            tpos_reg  <= tpos_next;
            j_reg     <= j_next;
            vld_reg   <= vld_next;
            found_reg <= found_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg    <= sym_next;
        fp_reg     <= fp_next;
        fs_reg     <= fs_next;
        jd_reg     <= jd_next;
        child_reg  <= child_next;
        n_reg      <= n_next;
        p_reg      <= p_next;
        s_reg      <= s_next;
        f_reg      <= f_next;
        o_reg      <= o_next;
        mn_reg     <= mn_next;
        ok_reg     <= ok_next;
        opid_reg   <= opid_next;
        ostart_reg <= ostart_next;
        ost_reg    <= ost_next;
        olast_reg  <= olast_next;
    end

    // two copies of parent/symbol: one swept for child search, one read by node
    mpsm_ram #(.WIDTH(NW + 8), .DEPTH(MAX_NODES)) u_psa (
        .clk(clk), .we(ps_we), .waddr(ps_wa), .wdata(ps_wd),
        .re(psa_re), .raddr(j_reg[NW-1:0]), .rdata(psa_rd)
    );
    mpsm_ram #(.WIDTH(NW + 8), .DEPTH(MAX_NODES)) u_psb (
        .clk(clk), .we(ps_we), .waddr(ps_wa), .wdata(ps_wd),
        .re(psb_re), .raddr(n_reg), .rdata(psb_rd)
    );
    mpsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
        .clk(clk), .we(fail_we), .waddr(fail_wa), .wdata(fail_wd),
        .re(info_re), .raddr(info_ra), .rdata(fail_rd)
    );
    mpsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_olink (
        .clk(clk), .we(olink_we), .waddr(olink_wa), .wdata(olink_wd),
        .re(info_re), .raddr(info_ra), .rdata(olink_rd)
    );
    mpsm_ram #(.WIDTH(PW + 1), .DEPTH(MAX_NODES)) u_term (
        .clk(clk), .we(tp_we), .waddr(tp_wa), .wdata(tp_wd),
        .re(info_re), .raddr(info_ra), .rdata(tp_rd)
    );
    mpsm_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_depth (
        .clk(clk), .we(dep_we), .waddr(nu_reg[NW-1:0]), .wdata(dep_wd),
        .re(info_re), .raddr(info_ra), .rdata(dep_rd)
    );
    mpsm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
        .re(q_re), .raddr(head_reg[NW-1:0]), .rdata(q_rd)
    );

    assign m_tvalid = ov_reg;
    assign m_tdata  = {6'd0, ost_reg, ostart_reg, opid_reg};
    assign m_tuser  = ok_reg;
    assign m_tlast  = olast_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/multi_pattern_string_matcher.sv =====
`default_nettype none
// Aho-Corasick keyword matcher. Send pattern bytes (tuser 0) and close each
// pattern with an end word (tuser 1), which returns one status word with the
// pattern id; then send text bytes (tuser 2), each returning one match word
// per pattern ending there (up to 32, tlast on the final one), or tuser 3 to
// restart the text at position 0. One word is handled at a time. Child
// lookups sweep the node table through one RAM read port, one entry a cycle,
// so a child lookup can sweep every node used so far. The first text byte
// after any insert word first rebuilds the failure and output links by a
// breadth-first walk, one child sweep per node plus one sweep per failure
// step, and restarts the scan at position 0.
module multi_pattern_string_matcher #(
    parameter int MAX_NODES    = mpsm_pkg::MAX_NODES_DEF,
    parameter int MAX_PATTERNS = mpsm_pkg::MAX_PATTERNS_DEF,
    parameter int MAX_DEPTH    = mpsm_pkg::MAX_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] pattern_id, [39:8] match_start,
                                        // [41:40] status, [47:42] zero
    output logic             m_tuser,   // [0] kind
    output logic             m_tlast    // final word for this input word
);

    mpsm_pkg::cmd_t cmd;
    mpsm_pkg::st_t  st;

    // sequencer: accepts words and steps the datapath
    mpsm_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_action(s_tuser),
        .s_tready(s_tready),
        .st(st),
        .cmd(cmd)
    );

    // node tables, walk queue, scan state and the output register
    mpsm_dpath #(
        .MAX_NODES(MAX_NODES),
        .MAX_PATTERNS(MAX_PATTERNS),
        .MAX_DEPTH(MAX_DEPTH)
    ) u_dpath (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .st(st),
        .in_action(s_tuser),
        .in_symbol(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/mpsm_checker.sv =====
`default_nettype none
module mpsm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("result changed while stalled");

    // a status word is always the only word of its end item
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == mpsm_pkg::KIND_STATUS |-> m_tlast && m_tdata[39:8] == 32'd0)
        else $error("status word malformed");

    // a match word carries no status
    a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == mpsm_pkg::KIND_MATCH |-> m_tdata[41:40] == mpsm_pkg::ST_OK)
        else $error("match word with status");

    // a failed insert carries id zero
    a_fail_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == mpsm_pkg::KIND_STATUS && m_tdata[41:40] != mpsm_pkg::ST_OK
        |-> m_tdata[7:0] == 8'd0)
        else $error("failed insert with id");

endmodule

bind multi_pattern_string_matcher mpsm_checker u_mpsm_checker (.*);
`default_nettype wire
